### src/csv_pkg.sv
// ---------------------------------------------------------------------------
// csv_pkg: shared types and constants for the CSR sparse matrix-vector unit
// Input kind codes, the decoded operation, the queue entry and queue status.
// ---------------------------------------------------------------------------
package csv_pkg;

  // default sizing
  localparam int DEF_VECTOR_DEPTH = 1024;
  localparam int DEF_FRAC_BITS    = 16;

  // fixed field widths
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 32;
  localparam int ROW_W     = 16;
  localparam int ACC_W     = 64;
  localparam int IN_DATA_W  = 48;  // index + value, padded to bytes
  localparam int OUT_DATA_W = 48;  // row_index + row_sum

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NZ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic                      in_range;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
  } q_entry_t;

  typedef struct packed {
    logic            pop;
    logic [Q_CW-1:0] cnt;
  } q_stat_t;

endpackage

### src/csr_sparse_matvec.sv
// ---------------------------------------------------------------------------
// csr_sparse_matvec: CSR sparse matrix times dense vector, signed fixed point
// Top level: row count register, front queue, MAC pipeline, output stage.
// ---------------------------------------------------------------------------
// Load the dense vector first (tuser = load, one element per request), then
// stream nonzeros row by row (tuser = nonzero, tlast on the last one of a
// row) or one empty-row request per empty row. Each row gives one result
// with its index, its Q16.16 sum (floored, saturated) and tlast on the final
// row as set by cfg_wdata (row count). The block takes one request per
// cycle, sustained, while out_tready stays high: each request makes a single
// pass through the vector store port, and each nonzero one 32x32 multiply.
// out_tvalid for a row rises once its closing request has passed the queue
// pop with store read, the multiply, the accumulate and the output register,
// each held while the output stalls. The vector store needs no clearing
// after reset; write row count only while no request is in flight.
module csr_sparse_matvec
  import csv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] index, [41:10] value
  input  logic [KIND_W-1:0]     in_tuser,   // [1:0] kind
  input  logic                  in_tlast,   // row_end
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] row_index, [47:16] row_sum
  output logic                  out_tlast,  // last_row
  // row count register
  input  logic                  cfg_we,
  input  logic [ROW_W-1:0]      cfg_wdata
);

  logic [ROW_W-1:0]        row_count_r;
  logic                    adv, pop;
  q_entry_t                head;
  q_stat_t                 qstat;
  logic                    res_vld, res_last;
  logic signed [ACC_W-1:0] res_sum;
  logic [ROW_W-1:0]        res_idx;

  // row count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_W'(1);
    end else if (cfg_we) begin
      row_count_r <= cfg_wdata;
    end
  end

  csv_front #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_index   (in_tdata[INDEX_W-1:0]),
    .in_value   (in_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .in_row_end (in_tlast),
    .adv        (adv),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  csv_mac #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .pop       (pop),
    .head      (head),
    .row_count (row_count_r),
    .res_vld   (res_vld),
    .res_sum   (res_sum),
    .res_idx   (res_idx),
    .res_last  (res_last)
  );

  csv_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res_sum    (res_sum),
    .res_idx    (res_idx),
    .res_last   (res_last),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // queue never pops when empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.pop |-> (qstat.cnt != '0))
    else $error("queue popped while empty");

  // queue never takes a request when full
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (qstat.cnt != Q_CW'(Q_DEPTH)))
    else $error("request accepted into full queue");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

### src/csv_front.sv
// ---------------------------------------------------------------------------
// csv_front: request intake and classification
// Decodes each request into an operation, checks the column against the
// vector depth, drops unknown kinds and holds ops in a two-entry queue.
// ---------------------------------------------------------------------------
module csv_front
  import csv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_row_end,
  input  logic                      adv,
  output logic                      pop,
  output q_entry_t                  head,
  output q_stat_t                   stat
);

  localparam logic [16:0] DEPTH_LIM = 17'(VECTOR_DEPTH);

  q_entry_t        q_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  q_entry_t        ent;
  logic            known;
  logic            push;

  // classify the incoming request
  always_comb begin
    ent          = '0;
    known        = 1'b1;
    ent.index    = in_index;
    ent.value    = in_value;
    ent.row_end  = in_row_end;
    ent.in_range = (17'(in_index) < DEPTH_LIM);
    case (in_kind)
      KIND_LOAD:  ent.op = OP_LOAD;
      KIND_NZ:    ent.op = OP_MAC;
      KIND_EMPTY: ent.op = OP_EMPTY;
      default: begin
        ent.op = OP_LOAD;
        known  = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push     = in_valid && in_ready && known;
  assign pop      = adv && (cnt_r != '0);
  assign head     = q_r[rd_ptr_r];
  assign stat     = '{pop: pop, cnt: cnt_r};

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= ent;
  end

endmodule

### src/csv_mac.sv
// ---------------------------------------------------------------------------
// csv_mac: vector store, multiply and row accumulate
// Stage 1 writes or reads the vector store, stage 2 multiplies, stage 3
// adds into the saturating row accumulator and closes rows.
// ---------------------------------------------------------------------------
module csv_mac
  import csv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEF_VECTOR_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    pop,
  input  q_entry_t                head,
  input  logic [ROW_W-1:0]        row_count,
  output logic                    res_vld,
  output logic signed [ACC_W-1:0] res_sum,
  output logic [ROW_W-1:0]        res_idx,
  output logic                    res_last
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [VALUE_W-1:0]        mem [VECTOR_DEPTH];
  logic [AW-1:0]             addr;
  logic                      wr_en;

  logic                      s1_vld_r;
  q_entry_t                  s1_r;
  logic signed [VALUE_W-1:0] rdata_r;
  logic                      s2_vld_r;
  op_t                       s2_op_r;
  logic                      s2_end_r;
  logic signed [ACC_W-1:0]   prod_nxt, prod_r;

  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ROW_W-1:0]          row_ctr_r, row_ctr_nxt;
  logic signed [ACC_W-1:0]   sum, sat;
  logic                      ovf, close, last;

  logic                      res_vld_r, res_last_r;
  logic signed [ACC_W-1:0]   res_sum_r;
  logic [ROW_W-1:0]          res_idx_r;

  assign addr  = AW'(17'(head.index));
  assign wr_en = pop && (head.op == OP_LOAD) && head.in_range;

  // stage 1: vector store access
  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) mem[addr] <= head.value;
      rdata_r <= mem[addr];
      s1_r    <= head;
    end
  end

  // stage 2: product, zero for loads, empty rows and out-of-range columns
  always_comb begin
    prod_nxt = '0;
    if (s1_r.op == OP_MAC && s1_r.in_range)
      prod_nxt = ACC_W'(s1_r.value) * ACC_W'(rdata_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod_nxt;
      s2_op_r  <= s1_r.op;
      s2_end_r <= s1_r.row_end;
    end
  end

  // stage 3: saturating accumulate, row close
  always_comb begin
    sum   = acc_r + prod_r;
    ovf   = (acc_r[ACC_W-1] == prod_r[ACC_W-1]) && (sum[ACC_W-1] != acc_r[ACC_W-1]);
    sat   = sum;
    if (ovf) sat = acc_r[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    close = s2_vld_r && ((s2_op_r == OP_EMPTY) || (s2_op_r == OP_MAC && s2_end_r));
    last  = ({1'b0, row_ctr_r} + 17'd1) >= {1'b0, row_count};

    acc_nxt     = acc_r;
    row_ctr_nxt = row_ctr_r;
    if (s2_vld_r && s2_op_r == OP_MAC) acc_nxt = sat;
    if (close) begin
      acc_nxt     = '0;
      row_ctr_nxt = last ? '0 : row_ctr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
      acc_r     <= '0;
      row_ctr_r <= '0;
    end else if (adv) begin
      s1_vld_r  <= pop;
      s2_vld_r  <= s1_vld_r;
      res_vld_r <= close;
      acc_r     <= acc_nxt;
      row_ctr_r <= row_ctr_nxt;
    end
  end

  // finished row
  always_ff @(posedge clk) begin
    if (adv) begin
      res_sum_r  <= sat;
      res_idx_r  <= row_ctr_r;
      res_last_r <= last;
    end
  end

  assign res_vld  = res_vld_r;
  assign res_sum  = res_sum_r;
  assign res_idx  = res_idx_r;
  assign res_last = res_last_r;

endmodule

### src/csv_out.sv
// ---------------------------------------------------------------------------
// csv_out: result scaling and output register
// Floors the accumulator down to the output format, saturates to 32 bits
// and holds the result until the consumer takes it.
// ---------------------------------------------------------------------------
module csv_out
  import csv_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_vld,
  input  logic signed [ACC_W-1:0] res_sum,
  input  logic [ROW_W-1:0]        res_idx,
  input  logic                    res_last,
  output logic                    adv,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic                    out_tlast
);

  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-VALUE_W:0]    hi;
  logic signed [VALUE_W-1:0] sat;
  logic                      vld_r;
  logic [OUT_DATA_W-1:0]     data_r;
  logic                      last_r;

  // pipeline moves whenever the output register is free or being drained
  assign adv = !vld_r || out_tready;

  // floor shift, then clamp to signed 32 bits
  always_comb begin
    shifted = res_sum >>> FRAC_BITS;
    hi      = shifted[ACC_W-1:VALUE_W-1];
    if ((&hi) || !(|hi)) sat = shifted[VALUE_W-1:0];
    else if (shifted[ACC_W-1]) sat = {1'b1, {(VALUE_W-1){1'b0}}};
    else sat = {1'b0, {(VALUE_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= {sat, res_idx};
      last_r <= res_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
